@@ hdl/lud_pkg.sv @@
// Shared types and constants for the lenient UTF-8 decoder.
// No dependencies; imported by every module in hdl/.
`timescale 1ns / 1ps
package lud_pkg;

    localparam int BYTE_W     = 8;
    localparam int CODE_W     = 21;
    localparam int LEN_W      = 3;
    localparam int PEND_W     = 2;
    localparam int OUT_DATA_W = 24;

    // lead byte classification
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_VAL  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_VAL  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_VAL  = 8'hF0;

    localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4 = 3'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] code_point;
        logic [LEN_W-1:0]  sequence_length;
    } cp_item_t;

endpackage

@@ hdl/lud_in_stage.sv @@
// Input register stage: holds one byte transaction for the decode stage.
// Depends on lud_pkg.
`timescale 1ns / 1ps
module lud_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lud_pkg::byte_item_t in_item,
    output logic              item_valid,
    input  logic              item_take,
    output lud_pkg::byte_item_t item
);
    import lud_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    byte_item_t item_reg;

    // free when empty or when the held byte is consumed this cycle
    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (item_take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ hdl/lud_decode.sv @@
// Decode stage: sequence state, byte classification and result register.
// Depends on lud_pkg.
`timescale 1ns / 1ps
module lud_decode
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_take,
    input  lud_pkg::byte_item_t item,
    output logic                res_valid,
    input  logic                res_ready,
    output lud_pkg::cp_item_t   res
);
    import lud_pkg::*;

    logic [PEND_W-1:0] pend_reg;
    logic [PEND_W-1:0] pend_next;
    logic [CODE_W-1:0] code_reg;
    logic [CODE_W-1:0] code_next;
    logic [LEN_W-1:0]  size_reg;
    logic [LEN_W-1:0]  size_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    cp_item_t          out_reg;
    logic [CODE_W-1:0] code_dec;
    logic [PEND_W-1:0] pend_dec;
    logic [LEN_W-1:0]  size_dec;
    logic              done;
    logic              emit;
    logic [BYTE_W-1:0] b;

    assign b = item.text_byte;

    // output register may be refilled in the cycle it drains
    assign item_take = item_valid && (!out_valid_reg || res_ready);

    always_comb
    begin
        code_dec = code_reg;
        pend_dec = pend_reg;
        size_dec = size_reg;
        done     = 1'b0;
        if (pend_reg != '0)
        begin
            // continuation: top bits ignored
            code_dec = {code_reg[CODE_W-7:0], b[5:0]};
            pend_dec = pend_reg - 1'b1;
            done     = (pend_reg == 2'd1);
        end
        else if (!b[7])
        begin
            code_dec = {{(CODE_W-BYTE_W){1'b0}}, b};
            size_dec = LEN_1;
            done     = 1'b1;
        end
        else if ((b & LEAD2_MASK) == LEAD2_VAL)
        begin
            code_dec = {{(CODE_W-5){1'b0}}, b[4:0]};
            size_dec = LEN_2;
            pend_dec = 2'd1;
        end
        else if ((b & LEAD3_MASK) == LEAD3_VAL)
        begin
            code_dec = {{(CODE_W-4){1'b0}}, b[3:0]};
            size_dec = LEN_3;
            pend_dec = 2'd2;
        end
        else if ((b & LEAD4_MASK) == LEAD4_VAL)
        begin
            code_dec = {{(CODE_W-3){1'b0}}, b[2:0]};
            size_dec = LEN_4;
            pend_dec = 2'd3;
        end
        // otherwise a stray byte: skipped

        emit = done && (code_dec != '0);

        if (done || item.last_byte)
        begin
            code_next = '0;
            pend_next = '0;
            size_next = '0;
        end
        else
        begin
            code_next = code_dec;
            pend_next = pend_dec;
            size_next = size_dec;
        end

        if (item_take)
        begin
            out_valid_next = emit;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            code_reg      <= '0;
            size_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (item_take)
            begin
                pend_reg <= pend_next;
                code_reg <= code_next;
                size_reg <= size_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take && emit)
        begin
            out_reg.code_point      <= code_dec;
            out_reg.sequence_length <= size_dec;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

@@ hdl/lenient_utf8_decoder.sv @@
// Top level of the lenient UTF-8 decoder: byte stream in, code points out.
// Depends on lud_pkg, lud_in_stage and lud_decode.
`timescale 1ns / 1ps
//
//  Channel   Dir  Payload                                    End of item
//  --------  ---  -----------------------------------------  ---------------------
//  s_axis    in   tdata[7:0] text_byte, tlast last_byte       tlast = end of string
//  m_axis    out  tdata[20:0] code_point, [23:21] seq length  -
//
//  One byte transaction per clock, sustained while m_axis is not stalled. A byte
//  is held in the input register once accepted, then the decode logic feeds the
//  result register. At most one code point leaves per byte.
//  Reset (rst_n low, asynchronous) empties both registers and clears the
//  pending sequence. A stall on m_axis holds the result register and backs
//  up through the input register to s_axis_tready; no transaction is dropped.
//
module lenient_utf8_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [20:0] code_point, [23:21] sequence_length
);
    import lud_pkg::*;

    byte_item_t in_item;
    byte_item_t held_item;
    logic       held_valid;
    logic       held_take;
    cp_item_t   res;

    assign in_item.text_byte = s_axis_tdata;
    assign in_item.last_byte = s_axis_tlast;

    lud_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (held_valid),
        .item_take  (held_take),
        .item       (held_item)
    );

    // sequence tracking and the result register
    lud_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (held_valid),
        .item_take  (held_take),
        .item       (held_item),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (res)
    );

    // code point in the low bits, length above it; exactly three bytes wide
    assign m_axis_tdata = {res.sequence_length, res.code_point};

endmodule

@@ tb/lud_checker.sv @@
// Checker for the lenient UTF-8 decoder: watches both stream channels and
// predicts every code point. Compares them field by field.
// Depends on lud_pkg only.
`timescale 1ns / 1ps
import lud_pkg::*;

module lud_checker
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,
    input  logic                  s_axis_tlast,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    output int                    mismatches,
    output int                    outstanding,
    output int                    bytes_in,
    output int                    codes_out
);

    typedef struct packed {
        logic [CODE_W-1:0] cp;
        logic [LEN_W-1:0]  len;
    } code_rec_t;

    code_rec_t         expected_codes[$];

    // shadow of the decoder state
    logic [PEND_W-1:0] cont_left;
    logic [CODE_W-1:0] code_acc;
    logic [LEN_W-1:0]  seq_bytes;

    // Advances the shadow state by one byte; returns 1 when a code point is due.
    function automatic logic decode_byte(input logic [BYTE_W-1:0] b, input logic last,
                                         output logic [CODE_W-1:0] cp,
                                         output logic [LEN_W-1:0] len);
        logic done;
        logic emit;
        done = 1'b0;
        if (cont_left != '0) begin
            // continuation: top bits ignored
            code_acc  = {code_acc[CODE_W-7:0], b[5:0]};
            cont_left = cont_left - 1'b1;
            done      = (cont_left == '0);
        end else if (!b[7]) begin
            code_acc  = CODE_W'(b);
            seq_bytes = LEN_1;
            done      = 1'b1;
        end else if ((b & LEAD2_MASK) == LEAD2_VAL) begin
            code_acc  = CODE_W'(b[4:0]);
            seq_bytes = LEN_2;
            cont_left = 2'd1;
        end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
            code_acc  = CODE_W'(b[3:0]);
            seq_bytes = LEN_3;
            cont_left = 2'd2;
        end else if ((b & LEAD4_MASK) == LEAD4_VAL) begin
            code_acc  = CODE_W'(b[2:0]);
            seq_bytes = LEN_4;
            cont_left = 2'd3;
        end
        // stray continuation or 11111xxx with nothing pending: skipped
        emit = done && (code_acc != '0);
        cp   = code_acc;
        len  = seq_bytes;
        if (done || last) begin
            cont_left = '0;
            code_acc  = '0;
            seq_bytes = '0;
        end
        return emit;
    endfunction

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        code_rec_t         got;
        code_rec_t         want;
        logic [CODE_W-1:0] cp;
        logic [LEN_W-1:0]  len;
        if (!rst_n) begin
            expected_codes.delete();
            cont_left   = '0;
            code_acc    = '0;
            seq_bytes   = '0;
            mismatches  = 0;
            outstanding = 0;
            bytes_in    = 0;
            codes_out   = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                bytes_in++;
                if (decode_byte(s_axis_tdata, s_axis_tlast, cp, len))
                    expected_codes.push_back('{cp: cp, len: len});
            end
            if (m_axis_tvalid && m_axis_tready) begin
                codes_out++;
                got.cp  = m_axis_tdata[CODE_W-1:0];
                got.len = m_axis_tdata[CODE_W +: LEN_W];
                if (expected_codes.size() == 0) begin
                    report($sformatf("unexpected code point %06h, length %0d",
                                     got.cp, got.len));
                end else begin
                    want = expected_codes.pop_front();
                    if (got.cp != want.cp)
                        report($sformatf("code_point: expected %06h, got %06h",
                                         want.cp, got.cp));
                    if (got.len != want.len)
                        report($sformatf("sequence_length: expected %0d, got %0d (cp %06h)",
                                         want.len, got.len, want.cp));
                end
            end
            outstanding = expected_codes.size();
        end
    end

endmodule

@@ tb/tb.sv @@
// Top of the lenient UTF-8 decoder testbench: clock, reset, byte stimulus,
// output back-pressure and the verdict. Depends on lud_pkg, lud_checker and the RTL.
`timescale 1ns / 1ps
import lud_pkg::*;

module tb;

    localparam int RANDOM_ITEMS = 1900;
    localparam int HOLD_CYCLES  = 80;    // long output stall, fills the pipeline
    localparam int STALL_LIMIT  = 4000;  // cycles without any transaction
    localparam int DRAIN_CYCLES = 8;     // two register stages plus margin

    // per phase: sender idle %, receiver idle %
    localparam int SRC_IDLE [3] = '{7, 64, 0};
    localparam int SINK_IDLE[3] = '{64, 7, 0};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int   mismatches;
    int   outstanding;
    int   bytes_in;
    int   codes_out;

    int   src_idle_pct = 0;
    int   sink_idle_pct = 0;
    logic hold_req = 1'b0;
    int   hold_count = 0;
    int   stall_cycles = 0;
    int   strings_sent = 0;
    logic [BYTE_W-1:0] burst[$];

    // {last, byte}: ASCII, zero byte, 2/3/4-byte forms up to the top code point,
    // stray continuation and 11111xxx leads, overlong zero, a surrogate, lead
    // bytes swallowed as continuations, and sequences cut short by the end mark
    logic [8:0] directed_bytes [0:24] = '{
        9'h100,
        9'h041, 9'h17F,
        9'h0C2, 9'h0A9,
        9'h0E2, 9'h082, 9'h1AC,
        9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,
        9'h080, 9'h0FF,
        9'h0C0, 9'h080,
        9'h0ED, 9'h0A0, 9'h080,
        9'h0E2, 9'h041, 9'h0C3,
        9'h1C3,
        9'h0E2, 9'h182
    };

    lenient_utf8_decoder uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lud_checker chk
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .bytes_in      (bytes_in),
        .codes_out     (codes_out)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Receiver: random back-pressure, plus one long hold-off once requested.
    // The hold is counted here so the sender keeps offering bytes meanwhile.
    always @(posedge clk)
    begin
        if (hold_req && hold_count < HOLD_CYCLES) begin
            hold_count    <= hold_count + 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Watchdog: a run that stops moving is a failure.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles, %0d code points outstanding",
                     STALL_LIMIT, outstanding);
            $display("tb failed");
            $finish;
        end
    end

    // One byte transaction, preceded by random idle cycles carrying junk data.
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= BYTE_W'($urandom);
            s_axis_tlast  <= 1'($urandom_range(0, 1));
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    initial
    begin : stimulus
        int          target;
        int          nchars;
        int          kind;
        int          nb;
        int          cut;
        logic        mark;
        logic [31:0] rnd;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening, no idling
        foreach (directed_bytes[i])
            push_byte(directed_bytes[i][7:0], directed_bytes[i][8]);

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct  = SRC_IDLE[ph];
            sink_idle_pct = SINK_IDLE[ph];
            // in the free-running phase stall the output for a long stretch
            if (ph == 2)
                hold_req <= 1'b1;
            target = bytes_in + RANDOM_ITEMS / 3;
            while (bytes_in < target) begin
                // build one string of mostly well-formed characters
                burst.delete();
                nchars = $urandom_range(1, 8);
                repeat (nchars) begin
                    kind = $urandom_range(0, 99);
                    rnd  = $urandom;
                    if (kind < 70) begin
                        nb = $urandom_range(1, 4);
                        case (nb)
                            1: burst.push_back({1'b0, rnd[6:0]});
                            2: burst.push_back({3'b110, rnd[4:0]});
                            3: burst.push_back({4'b1110, rnd[3:0]});
                            default: burst.push_back({5'b11110, rnd[2:0]});
                        endcase
                        for (int k = 1; k < nb; k++) begin
                            rnd = $urandom;
                            // now and then a continuation slot gets any byte at all
                            burst.push_back(rnd[31:29] == 3'd0 ? rnd[7:0]
                                                               : {2'b10, rnd[5:0]});
                        end
                    end else if (kind < 80) begin
                        // invalid lead
                        burst.push_back(rnd[8] ? {2'b10, rnd[5:0]} : {5'b11111, rnd[2:0]});
                    end else if (kind < 88) begin
                        // zero and its overlong forms
                        case (rnd[1:0])
                            2'd0: burst.push_back(8'h00);
                            2'd1: begin burst.push_back(8'hC0); burst.push_back(8'h80); end
                            2'd2:
                            begin
                                burst.push_back(8'hE0);
                                burst.push_back(8'h80);
                                burst.push_back(8'h80);
                            end
                            default:
                            begin
                                burst.push_back(8'hF0);
                                burst.push_back(8'h80);
                                burst.push_back(8'h80);
                                burst.push_back(8'h80);
                            end
                        endcase
                    end else begin
                        burst.push_back(rnd[7:0]);
                    end
                end
                // cut some strings short, often mid-sequence
                if ($urandom_range(0, 99) < 20 && burst.size() > 1) begin
                    cut = $urandom_range(1, burst.size() - 1);
                    repeat (cut) burst.delete(burst.size() - 1);
                end
                // a few strings run on into the next without an end mark
                mark = ($urandom_range(0, 99) < 90);
                foreach (burst[i])
                    push_byte(burst[i], mark && (i == burst.size() - 1));
                strings_sent++;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Decoded %0d bytes in %0d random strings (plus directed cases)",
                 bytes_in, strings_sent);
        $display("into %0d code points, under three idle mixes and one %0d-cycle output stall.",
                 codes_out, HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
